// ===== sv/aes128_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Substitution tables, round helpers and key schedule step for the cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

   typedef logic [127:0] block_type;

   localparam int NUM_ROUNDS = 10;

   localparam logic [0:255][7:0] SBOX = {
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [0:255][7:0] build_inv_sbox();
      logic [0:255][7:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[SBOX[i]] = i[7:0];
      end
      return t;
   endfunction

   localparam logic [0:255][7:0] INV_SBOX = build_inv_sbox();

   function automatic logic [7:0] get_byte(block_type s, int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type sub_bytes(block_type s, logic inv);
      block_type t;
      t = '0;
      for (int i = 0; i < 16; i++) begin
         t[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
      end
      return t;
   endfunction

   function automatic block_type shift_rows(block_type s, logic inv);
      block_type t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? 4 * ((c - r + 4) % 4) + r : 4 * ((c + r) % 4) + r;
            t[127 - 8 * (4 * c + r) -: 8] = get_byte(s, src);
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4 * c);
         a1 = get_byte(s, 4 * c + 1);
         a2 = get_byte(s, 4 * c + 2);
         a3 = get_byte(s, 4 * c + 3);
         t[127 - 32 * c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32 * c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111 - 32 * c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103 - 32 * c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   function automatic block_type inv_mix_columns(block_type s);
      block_type t;
      logic [3:0][7:0] a, m9, m11, m13, m14;
      logic [7:0] x2, x4, x8;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k] = get_byte(s, 4 * c + k);
            x2 = xtime(a[k]);
            x4 = xtime(x2);
            x8 = xtime(x4);
            m9[k] = x8 ^ a[k];
            m11[k] = x8 ^ x2 ^ a[k];
            m13[k] = x8 ^ x4 ^ a[k];
            m14[k] = x8 ^ x4 ^ x2;
         end
         t[127 - 32 * c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
         t[119 - 32 * c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
         t[111 - 32 * c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
         t[103 - 32 * c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
      end
      return t;
   endfunction

   function automatic block_type cipher_round(block_type s, logic inv, block_type key,
                                              logic last);
      block_type t;
      if (!inv) begin
         t = shift_rows(sub_bytes(s, 1'b0), 1'b0);
         if (!last) begin
            t = mix_columns(t);
         end
         t = t ^ key;
      end else begin
         t = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ key;
         if (!last) begin
            t = inv_mix_columns(t);
         end
      end
      return t;
   endfunction

   function automatic block_type next_round_key(block_type k, logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tw;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ tw;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

`default_nettype wire

// ===== sv/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled eleven-stage round pipeline with a stored round key schedule.
// ----------------------------------------------------------------------------
// One item enters per cycle unless the key rebuild or a stalled output holds
// it off. One stage holds the initial key addition and each of the ten rounds
// has a stage of its own. After reset and after every key register write the
// round keys are rebuilt one per cycle, and new items are held off meanwhile.
`default_nettype none

module aes128_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int NR = aes128_pkg::NUM_ROUNDS;

   logic [63:0] key_high_ff, key_low_ff;
   logic        busy_ff;
   logic [3:0]  cnt_ff;
   logic [7:0]  rc_ff;
   aes128_pkg::block_type work_ff;
   aes128_pkg::block_type rk_ff [0:NR];
   aes128_pkg::block_type next_key;

   aes128_pkg::block_type st_ff [0:NR];
   aes128_pkg::block_type st_in [0:NR];
   logic [NR:0] v_ff;
   logic [NR:0] kind_ff;
   logic        adv;
   logic        req_accept;

   assign csr_ready = 1'b1;
   assign adv = !(v_ff[NR] && rsp_stall);
   assign req_stall = busy_ff || !adv;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == 2'd0) begin
            key_high_ff <= csr_data;
         end else if (csr_index == 2'd1) begin
            key_low_ff <= csr_data;
         end
      end
   end

   assign next_key = aes128_pkg::next_round_key(work_ff, rc_ff);

   always_ff @(posedge clock) begin
      if (reset || csr_valid) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == 4'(NR)) begin
            busy_ff <= 1'b0;
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !csr_valid) begin
         if (cnt_ff == 4'd0) begin
            work_ff <= {key_high_ff, key_low_ff};
            rk_ff[0] <= {key_high_ff, key_low_ff};
            rc_ff <= 8'h01;
         end else begin
            work_ff <= next_key;
            rk_ff[cnt_ff] <= next_key;
            rc_ff <= aes128_pkg::xtime(rc_ff);
         end
      end
   end

   always_comb begin
      st_in[0] = {req_block_high, req_block_low} ^ (req_kind ? rk_ff[NR] : rk_ff[0]);
      for (int j = 1; j <= NR; j++) begin
         st_in[j] = aes128_pkg::cipher_round(st_ff[j - 1], kind_ff[j - 1],
                                             kind_ff[j - 1] ? rk_ff[NR - j] : rk_ff[j],
                                             j == NR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NR-1:0], req_accept};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st_in[0];
         kind_ff[0] <= req_kind;
         for (int j = 1; j <= NR; j++) begin
            st_ff[j] <= st_in[j];
            kind_ff[j] <= kind_ff[j - 1];
         end
      end
   end

   assign rsp_valid = v_ff[NR];
   assign rsp_result_high = st_ff[NR][127:64];
   assign rsp_result_low = st_ff[NR][63:0];

   a_write_starts_schedule: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> busy_ff && cnt_ff == 4'd0)
      else $error("Key write did not restart the round key schedule.");

   a_schedule_ends: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == 4'(NR) && !csr_valid |=> !busy_ff)
      else $error("Round key schedule did not finish after the last key.");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 4'd0)
      else $error("Schedule counter moved while idle.");

   a_no_entry_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && adv |=> !v_ff[0])
      else $error("An item entered while the round keys were being rebuilt.");

endmodule

`default_nettype wire
